@@ hw/rtl/ptc_pkg.sv @@
// Shared constants and types for the path traversal checker.
`default_nettype none

package ptc_pkg;

    // character codes
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // depth counter
    localparam int unsigned DEPTH_W = 13;
    localparam logic [DEPTH_W-1:0] DEPTH_TOP = {DEPTH_W{1'b1}};

    // saturating counters
    localparam logic [1:0] CNT_TOP = 2'd3;

    typedef logic [7:0] byte_t;

    // verdict handed from the core to the output stage
    typedef struct packed {
        logic fire;       // a verdict is produced by this word
        logic forbidden;  // the verdict
    } verdict_t;

endpackage

`default_nettype wire

@@ hw/rtl/ptc_core.sv @@
// Per-path rule state and the verdict logic for one path byte.
`default_nettype none

module ptc_core
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    accept,
    input  wire ptc_pkg::byte_t    path_byte,
    input  wire                    last_byte,
    output ptc_pkg::verdict_t      verdict
);

    // state
    ptc_pkg::byte_t                   win0_reg, win1_reg, win2_reg;
    logic [1:0]                       fill_reg, fill_next;
    logic [1:0]                       pos_reg, pos_next;
    logic [ptc_pkg::DEPTH_W-1:0]      depth_reg, depth_next;
    logic                             deny_reg, deny_next;
    logic                             das_reg, das_next;

    logic b_dot, b_slash;
    logic w1_dot, w2_dot, w2_slash;
    logic move_en, move_dec, move_hold;
    logic deny_now;

    assign b_dot    = (path_byte == ptc_pkg::CH_DOT);
    assign b_slash  = (path_byte == ptc_pkg::CH_SLASH);
    assign w1_dot   = (win1_reg == ptc_pkg::CH_DOT);
    assign w2_dot   = (win2_reg == ptc_pkg::CH_DOT);
    assign w2_slash = (win2_reg == ptc_pkg::CH_SLASH);

    // slash three bytes back resolves against the full lookahead
    assign move_en   = (fill_reg == ptc_pkg::CNT_TOP) && (win0_reg == ptc_pkg::CH_SLASH);
    assign move_dec  = w1_dot && w2_dot && b_slash;
    assign move_hold = w1_dot && w2_slash;

    // rule checks, including a step below zero
    always_comb
    begin
        deny_now = deny_reg;
        if ((pos_reg == 2'd1) && w2_dot && !b_slash)
        begin
            deny_now = 1'b1;
        end
        if ((pos_reg == 2'd2) && w1_dot && w2_dot && b_slash)
        begin
            deny_now = 1'b1;
        end
        depth_next = depth_reg;
        if (move_en)
        begin
            if (move_dec)
            begin
                if (depth_reg == '0)
                begin
                    deny_now = 1'b1;
                end
                else
                begin
                    depth_next = depth_reg - 1'b1;
                end
            end
            else if (!move_hold && (depth_reg != ptc_pkg::DEPTH_TOP))
            begin
                depth_next = depth_reg + 1'b1;
            end
        end
        deny_next = deny_now;
    end

    // byte right after the latest slash
    always_comb
    begin
        if (b_slash)
        begin
            das_next = 1'b0;
        end
        else if ((pos_reg != 2'd0) && w2_slash)
        begin
            das_next = b_dot;
        end
        else
        begin
            das_next = das_reg;
        end
    end

    // position and window fill counters
    always_comb
    begin
        fill_next = fill_reg;
        if ((pos_reg != 2'd0) && (fill_reg != ptc_pkg::CNT_TOP))
        begin
            fill_next = fill_reg + 1'b1;
        end
        pos_next = pos_reg;
        if (pos_reg != ptc_pkg::CNT_TOP)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // slashes still in the window at the end can only raise the depth,
    // so only the checks above decide the verdict
    assign verdict.fire      = accept && last_byte;
    assign verdict.forbidden = deny_next | das_next;

    // state registers, cleared after every verdict
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win0_reg  <= '0;
            win1_reg  <= '0;
            win2_reg  <= '0;
            fill_reg  <= '0;
            pos_reg   <= '0;
            depth_reg <= '0;
            deny_reg  <= 1'b0;
            das_reg   <= 1'b0;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                win0_reg  <= '0;
                win1_reg  <= '0;
                win2_reg  <= '0;
                fill_reg  <= '0;
                pos_reg   <= '0;
                depth_reg <= '0;
                deny_reg  <= 1'b0;
                das_reg   <= 1'b0;
            end
            else
            begin
                win0_reg  <= win1_reg;
                win1_reg  <= win2_reg;
                win2_reg  <= path_byte;
                fill_reg  <= fill_next;
                pos_reg   <= pos_next;
                depth_reg <= depth_next;
                deny_reg  <= deny_next;
                das_reg   <= das_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/path_traversal_checker.sv @@
// Path traversal checker: one path byte per word in, one verdict per path out.
// The verdict is registered and appears on the output in the cycle after the last byte is taken.
// One byte per cycle while the output register is empty or being read; the single output register frees as it is read.
// Reset (rst_n low, asynchronous): per-path state cleared and the output register emptied.
`default_nettype none

module path_traversal_checker
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire  [7:0] s_axis_tdata,   // [7:0] path_byte
    input  wire        s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] is_forbidden, [7:1] zero
);

    ptc_pkg::verdict_t verdict;
    logic              accept;
    logic              out_valid_reg;
    logic              out_forbidden_reg;

    // take a word whenever the output register is empty or being drained
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;

    ptc_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .path_byte (s_axis_tdata),
        .last_byte (s_axis_tlast),
        .verdict   (verdict)
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (verdict.fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict.fire)
        begin
            out_forbidden_reg <= verdict.forbidden;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_forbidden_reg};

endmodule

`default_nettype wire

@@ sim/path_traversal_checker_tb.sv @@
// Self-checking testbench for the path traversal checker: stream driver, verdict monitor, predictor.
`default_nettype none

module path_traversal_checker_tb;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned PHASE_BYTES    = 350;
    // lookahead byte that lies past the end of the path
    localparam logic [8:0]  PAST_END       = 9'h100;

    typedef enum logic [1:0] {MOVE_DOWN, MOVE_STAY, MOVE_UP} depth_move_t;

    typedef struct packed {
        ptc_pkg::byte_t path_byte;
        logic           last_byte;
    } path_word_t;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       s_axis_tvalid  = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata   = 8'h00;   // [7:0] path_byte
    logic       s_axis_tlast   = 1'b0;    // last_byte
    logic       m_axis_tvalid;
    logic       m_axis_tready  = 1'b0;
    logic [7:0] m_axis_tdata;             // [0] is_forbidden, [7:1] zero

    // stimulus control, changed only at the falling edge
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        rx_hold        = 1'b0;

    path_word_t  pending_bytes[$];
    logic        pending_verdicts[$];
    int unsigned error_count = 0;
    int unsigned quiet_cycles = 0;

    // predictor state for the path in flight
    ptc_pkg::byte_t               window[3]    = '{8'h00, 8'h00, 8'h00};
    logic [1:0]                   window_cnt   = 2'd0;
    logic [1:0]                   seen_cnt     = 2'd0;
    logic [ptc_pkg::DEPTH_W-1:0]  depth_lvl    = '0;
    logic                         denied       = 1'b0;
    logic                         dot_tail     = 1'b0;

    path_traversal_checker u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // effect on depth of the slash that precedes c1 c2 c3
    function automatic depth_move_t slash_move(logic [8:0] c1, logic [8:0] c2, logic [8:0] c3);
        if (c1 == {1'b0, ptc_pkg::CH_DOT} && c2 == {1'b0, ptc_pkg::CH_DOT}
            && c3 == {1'b0, ptc_pkg::CH_SLASH})
            return MOVE_DOWN;
        if (c1 == {1'b0, ptc_pkg::CH_DOT} && c2 == {1'b0, ptc_pkg::CH_SLASH})
            return MOVE_STAY;
        return MOVE_UP;
    endfunction

    task automatic apply_move(depth_move_t m);
        case (m)
            MOVE_DOWN:
            begin
                if (depth_lvl == '0)
                    denied = 1'b1;
                else
                    depth_lvl = depth_lvl - 1'b1;
            end
            MOVE_UP:
            begin
                if (depth_lvl != ptc_pkg::DEPTH_TOP)
                    depth_lvl = depth_lvl + 1'b1;
            end
            default:
            begin
            end
        endcase
    endtask

    // advance the predictor by one accepted word; a verdict is queued on the last byte
    task automatic judge_path_byte(ptc_pkg::byte_t b, logic last);
        logic [8:0] w1;
        logic [8:0] w2;
        logic [8:0] cb;
        logic [1:0] n;
        w1 = {1'b0, window[1]};
        w2 = {1'b0, window[2]};
        cb = {1'b0, b};
        n  = seen_cnt;

        // leading dot without a slash, leading "../"
        if (n == 2'd1 && window[2] == ptc_pkg::CH_DOT && b != ptc_pkg::CH_SLASH)
            denied = 1'b1;
        if (n == 2'd2 && window[1] == ptc_pkg::CH_DOT && window[2] == ptc_pkg::CH_DOT
            && b == ptc_pkg::CH_SLASH)
            denied = 1'b1;

        // byte after the latest slash
        if (b == ptc_pkg::CH_SLASH)
            dot_tail = 1'b0;
        else if (n >= 2'd1 && window[2] == ptc_pkg::CH_SLASH)
            dot_tail = (b == ptc_pkg::CH_DOT);

        // slash three bytes back now has its full lookahead
        if (window_cnt == ptc_pkg::CNT_TOP && window[0] == ptc_pkg::CH_SLASH)
            apply_move(slash_move(w1, w2, cb));

        if (last)
        begin
            // remaining slashes see the end of the path in their lookahead
            if (n == ptc_pkg::CNT_TOP && window[1] == ptc_pkg::CH_SLASH)
                apply_move(slash_move(w2, cb, PAST_END));
            if (n >= 2'd2 && window[2] == ptc_pkg::CH_SLASH)
                apply_move(slash_move(cb, PAST_END, PAST_END));
            if (n >= 2'd1 && b == ptc_pkg::CH_SLASH)
                apply_move(slash_move(PAST_END, PAST_END, PAST_END));
            pending_verdicts.push_back(denied | dot_tail);
            window     = '{8'h00, 8'h00, 8'h00};
            window_cnt = 2'd0;
            seen_cnt   = 2'd0;
            depth_lvl  = '0;
            denied     = 1'b0;
            dot_tail   = 1'b0;
        end
        else
        begin
            window[0] = window[1];
            window[1] = window[2];
            window[2] = b;
            if (n >= 2'd1 && window_cnt != ptc_pkg::CNT_TOP)
                window_cnt = window_cnt + 1'b1;
            if (seen_cnt != ptc_pkg::CNT_TOP)
                seen_cnt = seen_cnt + 1'b1;
        end
    endtask

    task automatic push_byte(ptc_pkg::byte_t b, logic last);
        path_word_t w;
        w.path_byte = b;
        w.last_byte = last;
        pending_bytes.push_back(w);
    endtask

    task automatic add_path(string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(ptc_pkg::byte_t'(s[i]), i == s.len() - 1);
    endtask

    // mostly segment-built paths, the rest raw noise bytes
    task automatic add_random_paths(int unsigned n_bytes);
        ptc_pkg::byte_t bytes[$];
        int unsigned    sent;
        int unsigned    segs;
        int unsigned    len;
        sent = 0;
        while (sent < n_bytes)
        begin
            bytes.delete();
            if ($urandom_range(9) < 7)
            begin
                if ($urandom_range(1) == 1)
                    bytes.push_back(ptc_pkg::CH_SLASH);
                segs = $urandom_range(1, 7);
                for (int k = 0; k < segs; k++)
                begin
                    if (k != 0)
                        bytes.push_back(ptc_pkg::CH_SLASH);
                    case ($urandom_range(5))
                        0, 1:
                        begin
                            bytes.push_back(ptc_pkg::CH_DOT);
                            bytes.push_back(ptc_pkg::CH_DOT);
                        end
                        2:
                            bytes.push_back(ptc_pkg::CH_DOT);
                        3:
                        begin
                        end
                        default:
                        begin
                            len = $urandom_range(1, 3);
                            for (int j = 0; j < len; j++)
                                bytes.push_back(ptc_pkg::byte_t'($urandom_range(255)));
                        end
                    endcase
                end
                if ($urandom_range(3) == 0)
                    bytes.push_back(ptc_pkg::CH_SLASH);
            end
            else
            begin
                len = $urandom_range(1, 12);
                for (int j = 0; j < len; j++)
                begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: bytes.push_back(ptc_pkg::CH_SLASH);
                        4, 5, 6:    bytes.push_back(ptc_pkg::CH_DOT);
                        default:    bytes.push_back(ptc_pkg::byte_t'($urandom_range(255)));
                    endcase
                end
            end
            foreach (bytes[i])
                push_byte(bytes[i], i == bytes.size() - 1);
            sent += bytes.size();
        end
    endtask

    // hold the sender until every queued word is taken and every verdict is back
    task automatic drain();
        while (pending_bytes.size() != 0 || s_axis_tvalid || pending_verdicts.size() != 0)
            @(negedge clk);
    endtask

    // driver: presents the next queued word whenever the current one is gone
    always @(posedge clk or negedge rst_n)
    begin : driver
        path_word_t nxt;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'h00;
            s_axis_tlast  <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                judge_path_byte(s_axis_tdata, s_axis_tlast);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.path_byte;
                    s_axis_tlast  <= nxt.last_byte;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each verdict word against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin : monitor
        logic want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected verdict word: expected none, got %02h",
                             $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (m_axis_tdata[0] !== want)
                    begin
                        $display("%0t: is_forbidden mismatch: expected %0b, got %0b",
                                 $time, want, m_axis_tdata[0]);
                        error_count++;
                    end
                    if (m_axis_tdata[7:1] !== 7'h00)
                    begin
                        $display("%0t: tdata padding mismatch: expected 00, got %02h",
                                 $time, m_axis_tdata[7:1]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog: too long without any word moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed paths, no idling
        add_path(".");
        add_path("/");
        add_path(".a");
        add_path("./x");
        add_path("../");
        add_path("a/../..");
        add_path("/.");
        add_path("a//");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b1);
        drain();

        // receiver holds off while the sender keeps offering words
        rx_hold = 1'b1;
        add_random_paths(PHASE_BYTES);
        repeat (HOLDOFF_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
        drain();

        send_idle_pct = 77;
        add_random_paths(PHASE_BYTES);
        drain();

        send_idle_pct  = 0;
        recv_stall_pct = 77;
        add_random_paths(PHASE_BYTES);
        drain();

        send_idle_pct  = 6;
        recv_stall_pct = 6;
        add_random_paths(PHASE_BYTES);
        drain();

        // let any stray verdict words arrive before the final check
        repeat (5) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
hw/rtl/ptc_pkg.sv
hw/rtl/ptc_core.sv
hw/rtl/path_traversal_checker.sv
sim/path_traversal_checker_tb.sv
